@@ hdl/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// shared request/response types and command codes of the paged lcd controller
// ----------------------------------------------------------------------------
package plc_pkg;

    // request types
    localparam logic [1:0] REQ_CMD_WRITE  = 2'd0;
    localparam logic [1:0] REQ_DATA_WRITE = 2'd1;
    localparam logic [1:0] REQ_DATA_READ  = 2'd2;

    // command bytes (base codes, low bits carry the operand)
    localparam logic [7:0] CMD_DISP_OFF   = 8'h3E;
    localparam logic [7:0] CMD_DISP_ON    = 8'h3F;
    localparam logic [7:0] CMD_SET_COL    = 8'h40;
    localparam logic [7:0] CMD_SET_PAGE   = 8'hB8;
    localparam logic [7:0] CMD_START_LINE = 8'hC0;

    // operand mask for column and start line commands
    localparam logic [5:0] LINE_MASK = 6'd63;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] chip_select;
        logic [7:0] bus_data;
    } plc_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       command_ignored;
        logic [1:0] display_enabled;
    } plc_rsp_t;

endpackage

@@ hdl/paged_lcd_controller.sv @@
// ----------------------------------------------------------------------------
// paged_lcd_controller
// display side of a two-half column/page graphic lcd with display ram
// ----------------------------------------------------------------------------
// usage:
//   requests arrive on req/req_valid/req_stall, one bus access each: command
//   write, data write or data read, with a two-bit half select.
//   every request yields exactly one response on rsp/rsp_valid/rsp_stall.
//   the response is registered in the output register, or in the skid entry
//   while the output register is held. throughput: one request per cycle
//   while req_stall is low; each half has its own single port ram, so a data
//   write to both halves or a read is one ram access per half per cycle.
//   a data read returns the output latch at once and reloads the latch from
//   ram; the ram data lands in the next cycle and is forwarded to a read that
//   follows back to back on the same half.
//   reset: all address, flag and latch registers clear, then a clearing
//   pass writes zero to every ram entry, PAGES*COLUMNS entries (512 by
//   default) in each half in parallel; req_stall stays high during it.
//   receiver stall: a skid entry behind the output register takes one more
//   response; after that req_stall rises until the receiver drains.
// ----------------------------------------------------------------------------
module paged_lcd_controller
    import plc_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int PAGES   = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  plc_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output plc_rsp_t rsp
);

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int PG_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [AW-1:0]    COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [8:0]       COLS_9    = 9'(COLUMNS);
    localparam logic [5:0]       PAGES_6   = 6'(PAGES);

    // column operand taken modulo COLUMNS by repeated compare and subtract
    function automatic logic [COL_W-1:0] col_of(input logic [7:0] b);
        logic [8:0] v;
        v = {3'b000, b[5:0] & LINE_MASK};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= COLS_9)
            begin
                v = v - COLS_9;
            end
        end
        return COL_W'(v);
    endfunction

    // page operand taken modulo PAGES
    function automatic logic [PG_W-1:0] page_of(input logic [7:0] b);
        logic [5:0] v;
        v = {3'b000, b[2:0]};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= PAGES_6)
            begin
                v = v - PAGES_6;
            end
        end
        return PG_W'(v);
    endfunction

    // per-half registers
    logic [COL_W-1:0] col_reg   [2];
    logic [COL_W-1:0] col_next  [2];
    logic [PG_W-1:0]  page_reg  [2];
    logic [PG_W-1:0]  page_next [2];
    logic [5:0]       start_reg [2];
    logic [5:0]       start_next[2];
    logic [7:0]       latch_reg [2];
    logic [7:0]       latch_next[2];
    logic [7:0]       latch_cur [2];
    logic [1:0]       disp_reg, disp_next;

    // pending latch reload from ram
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_half_reg, pend_half_next;

    // clearing pass
    logic             clearing_reg, clearing_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;

    // ram ports
    logic             ram_en   [2];
    logic             ram_we   [2];
    logic [AW-1:0]    ram_addr [2];
    logic [7:0]       ram_wdata[2];
    logic [7:0]       ram_rdata[2];

    logic             buf_full;
    logic             accept;
    logic             is_cmd, is_wr, is_rd;
    logic             cmd_disp, cmd_col, cmd_page, cmd_start, cmd_known;
    logic             rd_en, rd_half;
    logic [1:0]       wr_en, rd_sel;
    plc_rsp_t         rsp_next;

    assign req_stall = clearing_reg || buf_full;
    assign accept    = req_valid && !req_stall;

    // request decode
    always_comb
    begin
        is_cmd    = (req.req_type == REQ_CMD_WRITE);
        is_wr     = (req.req_type == REQ_DATA_WRITE);
        is_rd     = (req.req_type == REQ_DATA_READ);
        cmd_disp  = (req.bus_data[7:1] == CMD_DISP_ON[7:1]);
        cmd_col   = (req.bus_data[7:6] == CMD_SET_COL[7:6]);
        cmd_page  = (req.bus_data[7:3] == CMD_SET_PAGE[7:3]);
        cmd_start = (req.bus_data[7:6] == CMD_START_LINE[7:6]);
        cmd_known = cmd_disp || cmd_col || cmd_page || cmd_start;
        // half 0 answers a read when both are selected
        rd_half   = !req.chip_select[0];
        rd_en     = accept && is_rd && (req.chip_select != 2'b00);
        for (int h = 0; h < 2; h++)
        begin
            wr_en[h]  = accept && is_wr && req.chip_select[h];
            rd_sel[h] = rd_en && (rd_half == 1'(h));
        end
    end

    // per-half next state and ram port drive
    always_comb
    begin
        disp_next       = disp_reg;
        pend_valid_next = rd_en;
        pend_half_next  = rd_en ? rd_half : pend_half_reg;
        for (int h = 0; h < 2; h++)
        begin
            // latch value seen now, forwarding a reload still in flight
            latch_cur[h]  = (pend_valid_reg && (pend_half_reg == 1'(h))) ?
                            ram_rdata[h] : latch_reg[h];
            latch_next[h] = latch_cur[h];
            col_next[h]   = col_reg[h];
            page_next[h]  = page_reg[h];
            start_next[h] = start_reg[h];

            if (wr_en[h] || rd_sel[h])
            begin
                col_next[h] = (col_reg[h] == COL_LAST) ? '0 : col_reg[h] + 1'b1;
            end

            if (accept && is_cmd && req.chip_select[h])
            begin
                if (cmd_disp)
                begin
                    disp_next[h] = req.bus_data[0];
                end
                else if (cmd_col)
                begin
                    col_next[h] = col_of(req.bus_data);
                end
                else if (cmd_page)
                begin
                    page_next[h] = page_of(req.bus_data);
                end
                else if (cmd_start)
                begin
                    start_next[h] = req.bus_data[5:0] & LINE_MASK;
                end
            end

            ram_en[h]    = clearing_reg || wr_en[h] || rd_sel[h];
            ram_we[h]    = clearing_reg || wr_en[h];
            ram_addr[h]  = clearing_reg ? clr_cnt_reg :
                           AW'(page_reg[h]) * COLS_A + AW'(col_reg[h]);
            ram_wdata[h] = clearing_reg ? 8'h00 : req.bus_data;
        end
    end

    // clearing pass sequencing
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_LAST)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // response assembly, flags reported after the update
    always_comb
    begin
        rsp_next.read_data       = rd_en ? latch_cur[rd_half] : 8'h00;
        rsp_next.command_ignored = is_cmd && !cmd_known;
        rsp_next.display_enabled = disp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < 2; h++)
            begin
                col_reg[h]   <= '0;
                page_reg[h]  <= '0;
                start_reg[h] <= '0;
                latch_reg[h] <= '0;
            end
            disp_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_half_reg  <= 1'b0;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            for (int h = 0; h < 2; h++)
            begin
                col_reg[h]   <= col_next[h];
                page_reg[h]  <= page_next[h];
                start_reg[h] <= start_next[h];
                latch_reg[h] <= latch_next[h];
            end
            disp_reg       <= disp_next;
            pend_valid_reg <= pend_valid_next;
            pend_half_reg  <= pend_half_next;
            clearing_reg   <= clearing_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    // one display ram per half
    for (genvar g = 0; g < 2; g++)
    begin : g_half
        plc_half_ram #(
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .en    (ram_en[g]),
            .we    (ram_we[g]),
            .addr  (ram_addr[g]),
            .wdata (ram_wdata[g]),
            .rdata (ram_rdata[g])
        );
    end

    plc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (rsp_next),
        .full      (buf_full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

@@ hdl/plc_half_ram.sv @@
// ----------------------------------------------------------------------------
// plc_half_ram
// single port display ram of one controller half, registered read data
// ----------------------------------------------------------------------------
module plc_half_ram
    import plc_pkg::*;
#(
    parameter int DEPTH = 512
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/plc_out_buf.sv @@
// ----------------------------------------------------------------------------
// plc_out_buf
// response register with a skid entry so the request side keeps moving
// ----------------------------------------------------------------------------
module plc_out_buf
    import plc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  plc_rsp_t push_data,
    output logic     full,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output plc_rsp_t rsp
);

    logic     main_valid_reg, main_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    logic     load_main, load_skid;
    plc_rsp_t main_data_reg, skid_data_reg;
    plc_rsp_t main_src;

    logic     drain;

    always_comb
    begin
        drain           = main_valid_reg && !rsp_stall;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main       = 1'b0;
        load_skid       = 1'b0;
        main_src        = push_data;
        if (skid_valid_reg)
        begin
            // no push possible while the skid entry is occupied
            main_src = skid_data_reg;
            if (drain)
            begin
                load_main       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || drain)
            begin
                load_main       = 1'b1;
                main_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (drain)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main)
        begin
            main_data_reg <= main_src;
        end
        if (load_skid)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign rsp_valid = main_valid_reg;
    assign rsp       = main_data_reg;

endmodule
